/* rtl/priority_slot_replacer_unit_macros.svh */
// Assertion macros for the priority slot replacer.
// Used by the top level only; the macros expect clk_i and rst_ni in scope.
`ifndef PRIORITY_SLOT_REPLACER_UNIT_MACROS_SVH
`define PRIORITY_SLOT_REPLACER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define PRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// A consequent that must hold in the same cycle as its antecedent.
`define PRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// A consequent that must hold in the cycle after its antecedent.
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRS_ASSERT_ALWAYS(lbl, cond, msg)
`define PRS_ASSERT_SAME(lbl, ante, cons, msg)
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/prs_pkg.sv */
// Package for the priority slot replacer: slot constants, opcodes, the
// structs passed between the sequencer, the priority file and the top level.
// Depends on nothing.
package prs_pkg;

  // Slot layout of the protection unit.
  localparam int TotalSlots    = 12;
  localparam int ReservedSlots = 3;
  localparam bit NoUsers       = (TotalSlots <= ReservedSlots);
  localparam int UserSlots     = NoUsers ? 1 : (TotalSlots - ReservedSlots);

  // Field widths.
  localparam int SlotW  = 4;
  localparam int AddrW  = 32;
  localparam int PermW  = 32;
  localparam int PrioW  = 8;
  localparam int CntW   = 4;
  localparam int PrioAw = (TotalSlots > 1) ? $clog2(TotalSlots) : 1;

  localparam logic [SlotW-1:0] FirstSlot = SlotW'(ReservedSlots);
  localparam logic [SlotW-1:0] LastSlot  = SlotW'(TotalSlots - 1);
  localparam logic [CntW-1:0]  LastCnt   = CntW'(UserSlots - 1);

  // Operation codes of an input word.
  localparam logic OpPush  = 1'b0;
  localparam logic OpInval = 1'b1;

  // Write port of the priority file.
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    logic [PrioW-1:0] data;
  } prs_wr_t;

  // One slot write handed to the output register.
  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] slot;
    logic             enable;
    logic             last;
  } prs_emit_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic             idle;
    logic [SlotW-1:0] next_slot;
  } prs_stat_t;

  // A requested priority of zero counts as one.
  function automatic logic [PrioW-1:0] prs_eff_prio(input logic [PrioW-1:0] p);
    prs_eff_prio = (p == '0) ? PrioW'(1) : p;
  endfunction

  // Round-robin step over the user slots.
  function automatic logic [SlotW-1:0] prs_wrap(input logic [SlotW-1:0] s);
    prs_wrap = (s == LastSlot) ? FirstSlot : s + SlotW'(1);
  endfunction

endpackage

/* rtl/prs_ifs.sv */
// Handshake interfaces of the priority slot replacer: the request channel
// and the slot write channel. Depends on prs_pkg.
interface prs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [prs_pkg::AddrW-1:0]   region_start;
  logic [prs_pkg::AddrW-1:0]   region_end;
  logic [prs_pkg::PermW-1:0]   permissions;
  logic [prs_pkg::PrioW-1:0]   priority_req;

  modport source (output valid, operation, region_start, region_end, permissions,
                  priority_req, input ready);
  modport sink (input valid, operation, region_start, region_end, permissions,
                priority_req, output ready);
endinterface

interface prs_out_if;
  logic                        valid;
  logic                        ready;
  logic [prs_pkg::SlotW-1:0]   slot_number;
  logic [prs_pkg::AddrW-1:0]   out_start;
  logic [prs_pkg::AddrW-1:0]   out_end;
  logic [prs_pkg::PermW-1:0]   out_permissions;
  logic                        enable;
  logic                        last_write;

  modport source (output valid, slot_number, out_start, out_end, out_permissions,
                  enable, last_write, input ready);
  modport sink (input valid, slot_number, out_start, out_end, out_permissions,
                enable, last_write, output ready);
endinterface

/* rtl/prs_prio_file.sv */
// Stored replacement priority of every slot, one read and one write port.
// Depends on prs_pkg.
module prs_prio_file (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [prs_pkg::SlotW-1:0]   rd_addr_i,
  output logic [prs_pkg::PrioW-1:0]   rd_data_o,
  input  prs_pkg::prs_wr_t            wr_i
);

  logic [prs_pkg::PrioW-1:0] prio_q [prs_pkg::TotalSlots];

  // All priorities start at zero, so every slot is free after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < prs_pkg::TotalSlots; i++) begin
        prio_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      prio_q[wr_i.addr[prs_pkg::PrioAw-1:0]] <= wr_i.data;
    end
  end

  // The sequencer only ever addresses user slots.
  assign rd_data_o = prio_q[rd_addr_i[prs_pkg::PrioAw-1:0]];

endmodule

/* rtl/prs_seq.sv */
// Sequencer of the priority slot replacer: walks the user slots one per cycle
// unless the output stalls, through a single priority comparator and
// round-robin incrementer. Depends on prs_pkg.
module prs_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        op_i,
  input  logic [prs_pkg::PrioW-1:0]   prio_i,
  input  logic                        out_free_i,
  output logic [prs_pkg::SlotW-1:0]   rd_addr_o,
  input  logic [prs_pkg::PrioW-1:0]   rd_data_i,
  output prs_pkg::prs_wr_t            wr_o,
  output prs_pkg::prs_emit_t          emit_o,
  output prs_pkg::prs_stat_t          stat_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StInval = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [prs_pkg::SlotW-1:0] scan_q, scan_d;
  logic [prs_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [prs_pkg::SlotW-1:0] next_q, next_d;
  logic                      hit;
  logic                      scan_end;
  logic [prs_pkg::SlotW-1:0] scan_step;

  // The shared unit: one compare and one wrap step on the slot under test.
  assign hit       = (rd_data_i < prio_i);
  assign scan_end  = (cnt_q == prs_pkg::LastCnt);
  assign scan_step = prs_pkg::prs_wrap(scan_q);
  assign rd_addr_o = scan_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    cnt_d   = cnt_q;
    next_d  = next_q;
    wr_o    = '0;
    emit_o  = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i && !prs_pkg::NoUsers) begin
          if (op_i == prs_pkg::OpInval) begin
            state_d = StInval;
            scan_d  = prs_pkg::FirstSlot;
          end else begin
            state_d = StScan;
            scan_d  = next_q;
            cnt_d   = '0;
          end
        end
      end
      StScan: begin
        // A miss on the final slot overwrites that slot, which is the one
        // just before the pointer, and leaves the pointer where it is.
        if (hit || scan_end) begin
          if (out_free_i) begin
            wr_o    = '{en: 1'b1, addr: scan_q, data: prio_i};
            emit_o  = '{valid: 1'b1, slot: scan_q, enable: 1'b1, last: 1'b1};
            state_d = StIdle;
            if (hit) begin
              next_d = scan_step;
            end
          end
        end else begin
          scan_d = scan_step;
          cnt_d  = cnt_q + prs_pkg::CntW'(1);
        end
      end
      StInval: begin
        // One disable word per user slot, in ascending order.
        if (out_free_i) begin
          wr_o   = '{en: 1'b1, addr: scan_q, data: '0};
          emit_o = '{valid: 1'b1, slot: scan_q, enable: 1'b0,
                     last: (scan_q == prs_pkg::LastSlot)};
          if (scan_q == prs_pkg::LastSlot) begin
            next_d  = prs_pkg::FirstSlot;
            state_d = StIdle;
          end else begin
            scan_d = scan_q + prs_pkg::SlotW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      scan_q  <= prs_pkg::FirstSlot;
      cnt_q   <= '0;
      next_q  <= prs_pkg::FirstSlot;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      cnt_q   <= cnt_d;
      next_q  <= next_d;
    end
  end

  assign stat_o = '{idle: (state_q == StIdle), next_slot: next_q};

endmodule

/* rtl/priority_slot_replacer_unit.sv */
// Top level of the priority slot replacer: request capture, output register,
// sequencer and priority file. Depends on prs_pkg, prs_ifs, prs_prio_file,
// prs_seq and the assertion macro header.
//
//   Channel  Dir  Word carried
//   in_i     in   operation, region_start, region_end, permissions, priority_req
//   out_o    out  slot_number, out_start, out_end, out_permissions, enable, last_write
//
// A push is accepted and then compares up to nine user slots, one at a time, on
// the single priority comparator before its slot word is written to the output
// register. An invalidate gives nine disable words, one per cycle while the output
// register is free. A new word is taken as soon as the sequencer is idle, even while the
// last result waits in the output register; a stalled output holds the
// sequencer. Reset clears all priorities and points the scan at the first user slot.
`include "priority_slot_replacer_unit_macros.svh"

module priority_slot_replacer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  prs_in_if.sink       in_i,
  prs_out_if.source    out_o
);

  logic                        in_acc;
  logic                        out_free;
  logic [prs_pkg::AddrW-1:0]   start_q;
  logic [prs_pkg::AddrW-1:0]   end_q;
  logic [prs_pkg::PermW-1:0]   perm_q;
  logic [prs_pkg::PrioW-1:0]   prio_q;
  logic [prs_pkg::SlotW-1:0]   rd_addr;
  logic [prs_pkg::PrioW-1:0]   rd_data;
  prs_pkg::prs_wr_t            wr;
  prs_pkg::prs_emit_t          emit;
  prs_pkg::prs_stat_t          stat;
  logic                        ptr_ok;

  logic                        out_valid_q;
  logic [prs_pkg::SlotW-1:0]   out_slot_q;
  logic [prs_pkg::AddrW-1:0]   out_start_q;
  logic [prs_pkg::AddrW-1:0]   out_end_q;
  logic [prs_pkg::PermW-1:0]   out_perm_q;
  logic                        out_enable_q;
  logic                        out_last_q;

  assign in_i.ready = stat.idle;
  assign in_acc     = in_i.valid && stat.idle;
  assign out_free   = !out_valid_q || out_o.ready;

  // Capture of the request word.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      start_q <= in_i.region_start;
      end_q   <= in_i.region_end;
      perm_q  <= in_i.permissions;
      prio_q  <= prs_pkg::prs_eff_prio(in_i.priority_req);
    end
  end

  prs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .op_i       (in_i.operation),
    .prio_i     (prio_q),
    .out_free_i (out_free),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_o       (wr),
    .emit_o     (emit),
    .stat_o     (stat)
  );

  prs_prio_file u_prio_file (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word; a disable carries an all-zero descriptor.
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_slot_q   <= emit.slot;
      out_start_q  <= emit.enable ? start_q : '0;
      out_end_q    <= emit.enable ? end_q : '0;
      out_perm_q   <= emit.enable ? perm_q : '0;
      out_enable_q <= emit.enable;
      out_last_q   <= emit.last;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.slot_number     = out_slot_q;
  assign out_o.out_start       = out_start_q;
  assign out_o.out_end         = out_end_q;
  assign out_o.out_permissions = out_perm_q;
  assign out_o.enable          = out_enable_q;
  assign out_o.last_write      = out_last_q;

  // The scan pointer always names a user slot.
  assign ptr_ok = prs_pkg::NoUsers ||
                  ((stat.next_slot >= prs_pkg::FirstSlot) &&
                   (stat.next_slot <= prs_pkg::LastSlot));

  // Checks on the sequencer and the output register.
  `PRS_ASSERT_SAME(a_no_overwrite, emit.valid, out_free, "output word overwritten")
  `PRS_ASSERT_NEXT(a_last_idle, (emit.valid && emit.last), stat.idle, "busy after last word")
  `PRS_ASSERT_SAME(a_push_single, (emit.valid && emit.enable), emit.last, "push not single word")
  `PRS_ASSERT_ALWAYS(a_ptr_range, ptr_ok, "pointer outside user slots")

endmodule
